// ----- design/rcsc_pkg.sv -----
// Package for the record CRC-16 slot checker.
// Holds the shared types, status codes, the CRC byte-step function and the bit reversal.
// No dependencies.
package rcsc_pkg;

    localparam int CrcW   = 16;
    localparam int ByteW  = 8;
    localparam logic [CrcW-1:0] PolyReset = 16'h8005;

    // Classification of a finished record.
    typedef enum logic [1:0] {
        ST_NEW     = 2'd0,
        ST_USED    = 2'd1,
        ST_CORRUPT = 2'd2
    } t_status;

    // Snapshot of one record at its final byte, handed to the finish pipeline.
    typedef struct packed {
        logic [CrcW-1:0] crc;
        logic [CrcW-1:0] stored;
        logic            all_zero;
        logic            short_rec;
    } t_fin;

    // Shifts one byte into the CRC register, least significant bit first.
    // The polynomial is xored in whenever a one leaves the top bit.
    function automatic logic [CrcW-1:0] crc_shift8(
        input logic [CrcW-1:0]  crc_in,
        input logic [ByteW-1:0] data,
        input logic [CrcW-1:0]  poly
    );
        logic [CrcW-1:0] c;
        logic            top;
        c = crc_in;
        for (int i = 0; i < ByteW; i++) begin
            top = c[CrcW-1];
            c   = {c[CrcW-2:0], data[i]};
            if (top) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

    // Mirrors a 16-bit word end for end.
    function automatic logic [CrcW-1:0] reverse16(input logic [CrcW-1:0] v);
        logic [CrcW-1:0] r;
        for (int i = 0; i < CrcW; i++) begin
            r[CrcW-1-i] = v[i];
        end
        return r;
    endfunction

endpackage

// ----- design/record_crc16_slot_checker_core.sv -----
// Top level of the record CRC-16 slot checker.
// Depends on rcsc_pkg, rcsc_accum and rcsc_finish.
//
// Takes one record byte per transfer on the slave stream, tlast on the final
// byte, and returns one result per record on the master stream. A byte is
// accepted every cycle while the output side keeps up; the eight CRC bit steps
// for a held byte are done in the cycle that accepts the byte two places
// behind it. After the final byte of a record is accepted, its result is
// built in order: the record snapshot is taken at the accepting edge, one stage
// adds the first eight zero bits, and the result register takes the last
// eight, the reversal and the classification. Status is new for an all-zero
// record, used when the CRC over all bytes but the last two equals the stored
// checksum (high byte first), and corrupted otherwise, including any non-zero
// record shorter than three bytes. The polynomial register resets to 0x8005;
// the finish stages use it too, so it should be written only while no record
// and no result is in flight.
module record_crc16_slot_checker_core
    import rcsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: polynomial write.
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // Slave stream: record bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] record_byte
    input  logic        s_axis_tlast,   // last_byte
    // Master stream: record results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [1:0] record_status, [17:2] computed_crc,
                                        // [33:18] stored_crc, [39:34] zero
);

    logic [CrcW-1:0] r_poly;
    logic            in_fire;
    logic            fin_valid;
    logic            fin_ready;
    t_fin            fin;
    t_status         status;
    logic [CrcW-1:0] computed;
    logic [CrcW-1:0] stored;

    // Polynomial register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= PolyReset;
        end else if (i_cfg_wr_en) begin
            r_poly <= i_cfg_wr_data;
        end
    end

    assign s_axis_tready = fin_ready | ~fin_valid;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    rcsc_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_poly      (r_poly),
        .i_in_fire   (in_fire),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_fin_ready (fin_ready),
        .o_fin_valid (fin_valid),
        .o_fin       (fin)
    );

    rcsc_finish u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_poly      (r_poly),
        .i_fin_valid (fin_valid),
        .i_fin       (fin),
        .o_fin_ready (fin_ready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (status),
        .o_computed  (computed),
        .o_stored    (stored)
    );

    // Pack the result fields, highest field first.
    assign m_axis_tdata = {6'b0, stored, computed, status};

endmodule

// ----- design/rcsc_accum.sv -----
// Per-byte accumulation stage of the record checker.
// Depends on rcsc_pkg for the CRC step function and the t_fin snapshot type.
module rcsc_accum
    import rcsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CrcW-1:0]  i_poly,
    input  logic             i_in_fire,
    input  logic [ByteW-1:0] i_byte,
    input  logic             i_last,
    input  logic             i_fin_ready,
    output logic             o_fin_valid,
    output t_fin             o_fin
);

    logic [CrcW-1:0]  r_crc;
    logic [ByteW-1:0] r_held0;
    logic [ByteW-1:0] r_held1;
    logic [1:0]       r_cnt;
    logic             r_all_zero;
    logic             r_fin_valid;
    t_fin             r_fin;

    logic [CrcW-1:0]  n_crc;
    logic [1:0]       n_cnt;
    logic             n_all_zero;

    // The oldest held byte joins the CRC once two newer bytes follow it.
    always_comb begin
        n_crc      = r_cnt[1] ? crc_shift8(r_crc, r_held0, i_poly) : r_crc;
        n_cnt      = (r_cnt == 2'd3) ? r_cnt : r_cnt + 2'd1;
        n_all_zero = r_all_zero & (i_byte == '0);
    end

    // Record state; it returns to its cleared form after the final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= '0;
            r_held0    <= '0;
            r_held1    <= '0;
            r_cnt      <= '0;
            r_all_zero <= 1'b1;
        end else if (i_in_fire) begin
            if (i_last) begin
                r_crc      <= '0;
                r_held0    <= '0;
                r_held1    <= '0;
                r_cnt      <= '0;
                r_all_zero <= 1'b1;
            end else begin
                r_crc      <= n_crc;
                r_held0    <= r_held1;
                r_held1    <= i_byte;
                r_cnt      <= n_cnt;
                r_all_zero <= n_all_zero;
            end
        end
    end

    // Snapshot register for a completed record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (i_in_fire && i_last) begin
            r_fin_valid <= 1'b1;
        end else if (i_fin_ready) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire && i_last) begin
            r_fin.crc       <= n_crc;
            r_fin.stored    <= {r_held1, i_byte};
            r_fin.all_zero  <= n_all_zero;
            r_fin.short_rec <= ~r_cnt[1];
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

endmodule

// ----- design/rcsc_finish.sv -----
// Finish pipeline of the record checker: zero augmentation in two halves,
// bit reversal, classification and the output register. Depends on rcsc_pkg.
module rcsc_finish
    import rcsc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [CrcW-1:0] i_poly,
    input  logic            i_fin_valid,
    input  t_fin            i_fin,
    output logic            o_fin_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output t_status         o_status,
    output logic [CrcW-1:0] o_computed,
    output logic [CrcW-1:0] o_stored
);

    logic            r_mid_valid;
    t_fin            r_mid;
    logic            r_out_valid;
    t_status         r_status;
    logic [CrcW-1:0] r_computed;
    logic [CrcW-1:0] r_stored;

    logic            out_ready;
    logic            mid_ready;
    logic [CrcW-1:0] n_computed;
    t_status         n_status;

    assign out_ready   = ~r_out_valid | i_out_ready;
    assign mid_ready   = ~r_mid_valid | out_ready;
    assign o_fin_ready = mid_ready;

    // First eight zero bits of the augmentation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (mid_ready) begin
            r_mid_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_ready && i_fin_valid) begin
            r_mid.crc       <= crc_shift8(i_fin.crc, '0, i_poly);
            r_mid.stored    <= i_fin.stored;
            r_mid.all_zero  <= i_fin.all_zero;
            r_mid.short_rec <= i_fin.short_rec;
        end
    end

    // Last eight zero bits, reversal and classification.
    always_comb begin
        n_computed = reverse16(crc_shift8(r_mid.crc, '0, i_poly));
        priority if (r_mid.all_zero) begin
            n_status = ST_NEW;
        end else if (r_mid.short_rec) begin
            n_status = ST_CORRUPT;
        end else if (n_computed == r_mid.stored) begin
            n_status = ST_USED;
        end else begin
            n_status = ST_CORRUPT;
        end
    end

    // Result register; it holds its transfer until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_mid_valid) begin
            r_status   <= n_status;
            r_computed <= n_computed;
            r_stored   <= r_mid.stored;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_computed  = r_computed;
    assign o_stored    = r_stored;

endmodule
